/* hdl/bba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // bitmap geometry
    localparam int MAX_BYTES  = 128;
    localparam int BYTE_AW    = $clog2(MAX_BYTES);
    localparam int GRP_BYTES  = 8;
    localparam int GROUPS     = MAX_BYTES / GRP_BYTES;
    localparam int GRP_AW     = $clog2(GROUPS);
    localparam int SUB_AW     = $clog2(GRP_BYTES);
    localparam int BLK_W      = 10;
    localparam int CFG_W      = 8;
    localparam logic [7:0] BYTE_FULL = 8'hFF;

    // request kinds
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOSPACE      = 2'd1,
        ST_ALREADY_FREE = 2'd2,
        ST_RANGE        = 2'd3
    } t_status;

    // input word
    typedef struct packed {
        logic              func;
        logic [BLK_W-1:0]  block_in;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [1:0]        status;
        logic [BLK_W-1:0]  blk_num;
    } t_out_word;

    // first-fit search result
    typedef struct packed {
        logic               hit;
        logic [BYTE_AW-1:0] idx;
    } t_find_res;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FIND,
        S_READ,
        S_MOD
    } t_state;

endpackage
`default_nettype wire

/* hdl/bitmap_block_allocator_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_block_allocator_unit
// First-fit block allocator over a 128-byte usage bitmap.
// ----------------------------------------------------------------------------
// The usage bitmap sits in a 128 x 8 synchronous RAM; per-byte valid bits
// make it read as all-free right after reset, and per-byte full flags feed a
// registered two-level first-fit search. One request is handled at a time:
// an allocate passes through accept and search summary, byte select, RAM
// read, and modify and write back; a free skips the search and goes from
// accept to RAM read and then modify and write back. Each modify waits on
// a registered RAM read. The result sits in an output register, so the
// next word is accepted while it waits; a stalled result holds the
// following request in its write-back cycle. The r_bytes register (values
// above 128 act as 128) is written through the configuration channel,
// which is always ready; the user is to write it only while the unit is
// idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit
    import bba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // request channel
    input  wire logic             i_in_valid,
    input  wire t_in_word         i_in_word,
    output logic                  o_in_stall,
    // result channel
    output logic                  o_out_valid,
    output t_out_word             o_out_word,
    input  wire logic             i_out_stall,
    // configuration channel
    input  wire logic             i_cfg_valid,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_bytes;
    logic [CFG_W-1:0]     act_bytes;
    logic [MAX_BYTES-1:0] r_full;
    logic [MAX_BYTES-1:0] r_vld;
    logic [MAX_BYTES-1:0] avail;
    logic [7:0]           r_mem [0:MAX_BYTES-1];
    logic [7:0]           r_rdata;

    logic                 r_func;
    logic [2:0]           r_bit;
    logic [BYTE_AW-1:0]   r_byte;
    logic                 r_skip;
    t_status              r_status;

    logic                 r_out_valid;
    t_out_word            r_out_word;

    t_find_res            find_res;
    logic                 in_acc;
    logic                 out_free;
    logic                 leave_mod;
    logic [7:0]           cur;
    logic [7:0]           new_byte;
    logic [2:0]           zbit;
    logic                 do_wr;
    t_status              res_status;
    logic [BLK_W-1:0]     res_blk;
    logic [BYTE_AW:0]     in_byte;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= CFG_W'(MAX_BYTES);
        end else if (i_cfg_valid) begin
            r_bytes <= i_cfg_data;
        end
    end
    assign act_bytes = (r_bytes > CFG_W'(MAX_BYTES)) ? CFG_W'(MAX_BYTES) : r_bytes;

    // bytes in range that still have a clear bit
    always_comb begin
        for (int b = 0; b < MAX_BYTES; b++) begin
            avail[b] = !r_full[b] && (CFG_W'(b) < act_bytes);
        end
    end

    bba_find u_find (
        .i_clk   (i_clk),
        .i_avail (avail),
        .o_res   (find_res)
    );

    // handshake helpers
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign in_byte  = {1'b0, i_in_word.block_in[BLK_W-1:3]};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_in_word.func == FUNC_FREE) ? S_READ : S_FIND;
                end
            end
            S_FIND:  n_state = S_READ;
            S_READ:  n_state = S_MOD;
            S_MOD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // state outputs
    always_comb begin
        o_in_stall = 1'b1;
        leave_mod  = 1'b0;
        unique case (r_state)
            S_IDLE:  o_in_stall = 1'b0;
            S_MOD:   leave_mod  = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    // request capture, search result, range check
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_func <= i_in_word.func;
            r_bit  <= i_in_word.block_in[2:0];
            r_byte <= in_byte[BYTE_AW-1:0];
            if (i_in_word.func == FUNC_FREE && in_byte >= (BYTE_AW+1)'(act_bytes)) begin
                r_skip   <= 1'b1;
                r_status <= ST_RANGE;
            end else begin
                r_skip   <= 1'b0;
                r_status <= ST_OK;
            end
        end else if (r_state == S_FIND) begin
            r_byte <= find_res.idx;
            if (!find_res.hit) begin
                r_skip   <= 1'b1;
                r_status <= ST_NOSPACE;
            end
        end
    end

    // lowest clear bit of the current byte
    assign cur = r_vld[r_byte] ? r_rdata : 8'h00;
    always_comb begin
        zbit = '0;
        for (int i = 7; i >= 0; i--) begin
            if (!cur[i]) begin
                zbit = 3'(i);
            end
        end
    end

    // read-modify-write decision
    always_comb begin
        new_byte   = cur;
        do_wr      = 1'b0;
        res_status = r_status;
        res_blk    = '0;
        if (r_skip) begin
            res_status = r_status;
        end else if (r_func == FUNC_ALLOC) begin
            new_byte   = cur | (8'h01 << zbit);
            do_wr      = 1'b1;
            res_status = ST_OK;
            res_blk    = BLK_W'({r_byte, zbit});
        end else if (!cur[r_bit]) begin
            res_status = ST_ALREADY_FREE;
        end else begin
            new_byte   = cur & ~(8'h01 << r_bit);
            do_wr      = 1'b1;
            res_status = ST_OK;
        end
    end

    // bitmap RAM
    always_ff @(posedge i_clk) begin
        if (leave_mod && do_wr) begin
            r_mem[r_byte] <= new_byte;
        end
        r_rdata <= r_mem[r_byte];
    end

    // per-byte valid and full flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_full <= '0;
        end else if (leave_mod && do_wr) begin
            r_vld[r_byte]  <= 1'b1;
            r_full[r_byte] <= (new_byte == BYTE_FULL);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (leave_mod) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (leave_mod) begin
            r_out_word.status  <= res_status;
            r_out_word.blk_num <= res_blk;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule
`default_nettype wire

/* hdl/bba_find.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bba_find
// Two-level first-fit search over the per-byte availability flags. The
// group summary is registered; the result is valid the cycle after the
// flags settle and while they stay unchanged.
// ----------------------------------------------------------------------------
module bba_find
    import bba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic [MAX_BYTES-1:0] i_avail,
    output t_find_res                 o_res
);

    logic [GROUPS-1:0]    r_grp_any;
    logic [GRP_AW-1:0]    grp_idx;
    logic                 grp_hit;
    logic [SUB_AW-1:0]    sub_idx;
    logic [GRP_BYTES-1:0] grp_bits;

    // group summary: any available byte in each group
    always_ff @(posedge i_clk) begin
        for (int g = 0; g < GROUPS; g++) begin
            r_grp_any[g] <= |i_avail[g*GRP_BYTES +: GRP_BYTES];
        end
    end

    // lowest group with space
    always_comb begin
        grp_hit = 1'b0;
        grp_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                grp_hit = 1'b1;
                grp_idx = GRP_AW'(g);
            end
        end
    end

    // lowest byte with space inside that group
    always_comb begin
        grp_bits = i_avail[grp_idx*GRP_BYTES +: GRP_BYTES];
        sub_idx  = '0;
        for (int b = GRP_BYTES - 1; b >= 0; b--) begin
            if (grp_bits[b]) begin
                sub_idx = SUB_AW'(b);
            end
        end
    end

    assign o_res.hit = grp_hit;
    assign o_res.idx = {grp_idx, sub_idx};

endmodule
`default_nettype wire
